// File: rtl/dlfc_pkg.sv
`timescale 1ns / 1ps

package dlfc_pkg;

	// field limits
	localparam int MaxFieldsDefault = 8;

	// characters with a fixed meaning
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_COMMENT = 8'h23;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0D;

	// result status codes
	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_LONG = 3'd1;
	localparam logic [2:0] ST_FEW = 3'd2;
	localparam logic [2:0] ST_MANY = 3'd3;
	localparam logic [2:0] ST_WIDE = 3'd4;

	// configuration register indexes
	localparam logic [1:0] REG_DELIMITER = 2'd0;
	localparam logic [1:0] REG_FIELD_COUNT = 2'd1;
	localparam logic [1:0] REG_BUFFER_SIZE = 2'd2;
	localparam logic [1:0] REG_FIELD_WIDTHS = 2'd3;

	// reset values of the registers
	localparam logic [7:0] DELIMITER_RESET = 8'd59;
	localparam logic [3:0] FIELD_COUNT_RESET = 4'd3;
	localparam logic [15:0] BUFFER_SIZE_RESET = 16'd256;
	localparam logic [63:0] FIELD_WIDTHS_RESET = '1;

	localparam logic [23:0] LINES_MAX = 24'hFFFFFF;

	typedef struct packed {
		logic [7:0]  delimiter;
		logic [3:0]  field_count;
		logic [15:0] buf_size;
		logic [63:0] field_widths;
	} cfg_t;

	typedef struct packed {
		logic is_newline;
		logic is_comment;
		logic is_delim;
		logic is_space;
	} byte_class_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [23:0] line_number;
		logic [3:0]  field_number;
	} result_t;

endpackage

// File: rtl/delimited_line_field_checker.sv
`timescale 1ns / 1ps
// channel  direction  handshake            payload
// in       to block   in_valid / in_stall   text_byte, end_of_input
// out      from block out_valid / out_stall status, line_number, field_number
// cfg      to block   cfg_we               cfg_index, cfg_data
//
// one item a cycle unless in_stall: an item is registered, then line-state logic
// updates the counters and, on an end item, loads the result register.
// out_valid is set as the end item leaves stage one, once the output is free.
// reset clears all counters and flags and loads the register reset values.
// in_stall rises only when an end item waits while an earlier result is stalled.

module delimited_line_field_checker #(
	parameter int MAX_FIELDS = dlfc_pkg::MaxFieldsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  text_byte,
	input  logic        end_of_input,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [23:0] line_number,
	output logic [3:0]  field_number,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import dlfc_pkg::*;

	cfg_t        cfg_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eoi_s1;
	logic        advance;
	byte_class_t cls;
	result_t     res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delimiter <= DELIMITER_RESET;
			cfg_q.field_count <= FIELD_COUNT_RESET;
			cfg_q.buf_size <= BUFFER_SIZE_RESET;
			cfg_q.field_widths <= FIELD_WIDTHS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DELIMITER: cfg_q.delimiter <= cfg_data[7:0];
				REG_FIELD_COUNT: cfg_q.field_count <= cfg_data[3:0];
				REG_BUFFER_SIZE: cfg_q.buf_size <= cfg_data[15:0];
				REG_FIELD_WIDTHS: cfg_q.field_widths <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage one holds an item unless an end item meets a full, stalled output
	assign advance = valid_s1 && !(eoi_s1 && out_valid && out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= text_byte;
			eoi_s1 <= end_of_input;
		end
	end

	dlfc_byte_class u_class (
		.text_byte (byte_s1),
		.delimiter (cfg_q.delimiter),
		.cls       (cls)
	);

	dlfc_line_state #(
		.MAX_FIELDS (MAX_FIELDS)
	) u_state (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.end_item (eoi_s1),
		.cls      (cls),
		.cfg      (cfg_q),
		.result   (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance && eoi_s1) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && eoi_s1) begin
			status <= res.status;
			line_number <= res.line_number;
			field_number <= res.field_number;
		end
	end

`ifndef SYNTHESIS
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (eoi_s1 && out_valid && out_stall))
		else $error("input stalled without a blocked result");
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s1 && eoi_s1))
		else $error("result without an end item");
	a_ok_no_field: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_OK) |-> (field_number == 4'd0))
		else $error("field number set on ok status");
	a_field_wide: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && field_number != 4'd0) |-> (status == ST_WIDE))
		else $error("field number set without width error");
`endif

endmodule

// File: rtl/dlfc_byte_class.sv
`timescale 1ns / 1ps

module dlfc_byte_class (
	input  logic [7:0]          text_byte,
	input  logic [7:0]          delimiter,
	output dlfc_pkg::byte_class_t cls
);
	import dlfc_pkg::*;

	// c-locale whitespace: space, tab through carriage return
	always_comb begin
		cls.is_newline = (text_byte == CH_NEWLINE);
		cls.is_comment = (text_byte == CH_COMMENT);
		cls.is_delim = (text_byte == delimiter);
		cls.is_space = (text_byte == CH_SPACE) ||
			((text_byte >= CH_TAB) && (text_byte <= CH_CR));
	end

endmodule

// File: rtl/dlfc_line_state.sv
`timescale 1ns / 1ps

module dlfc_line_state #(
	parameter int MAX_FIELDS = dlfc_pkg::MaxFieldsDefault
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic                  end_item,
	input  dlfc_pkg::byte_class_t cls,
	input  dlfc_pkg::cfg_t        cfg,
	output dlfc_pkg::result_t     result
);
	import dlfc_pkg::*;

	localparam logic [3:0] MaxF = 4'(MAX_FIELDS);

	logic [23:0] lines_q;
	logic [15:0] bytes_q;
	logic [3:0]  field_q;
	logic        comment_q;
	logic        content_q;
	logic        started_q;
	logic [7:0]  trim_q;
	logic [7:0]  spaces_q;
	logic [2:0]  lerr_q;
	logic [3:0]  lerr_field_q;
	logic [2:0]  ferr_q;
	logic [23:0] ferr_line_q;
	logic [3:0]  ferr_field_q;

	logic [3:0]  wanted;
	logic [7:0]  lim;
	logic [15:0] bytes_inc;
	logic [15:0] limit;
	logic [15:0] line_bytes;
	logic        terminated;
	logic        do_close_line;
	// close of the current field
	logic [2:0]  cf_err;
	logic [3:0]  cf_err_field;
	logic [3:0]  cf_field;
	// close of the current line
	logic [2:0]  cl_lerr;
	logic [2:0]  cl_err;
	logic [23:0] cl_lines;
	logic [2:0]  cl_ferr;
	logic [23:0] cl_ferr_line;
	logic [3:0]  cl_ferr_field;
	logic [8:0]  trim_sum;

	// field count capped at the field limit
	assign wanted = (cfg.field_count > MaxF) ? MaxF : cfg.field_count;

	// width limit of the current field
	always_comb begin
		lim = 8'hFF;
		for (int i = 0; i < MAX_FIELDS; i++) begin
			if (field_q == 4'(i)) lim = cfg.field_widths[i*8 +: 8];
		end
	end

	// closing a field checks its width or counts an extra field
	always_comb begin
		cf_err = lerr_q;
		cf_err_field = lerr_field_q;
		if (field_q < wanted) begin
			if (lim != 8'hFF && trim_q >= lim && lerr_q == ST_OK) begin
				cf_err = ST_WIDE;
				cf_err_field = field_q + 4'd1;
			end
		end else if (lerr_q == ST_OK) begin
			cf_err = ST_MANY;
		end
		cf_field = (field_q < 4'd15) ? field_q + 4'd1 : field_q;
	end

	assign bytes_inc = (bytes_q < 16'hFFFF) ? bytes_q + 16'd1 : bytes_q;
	assign limit = (cfg.buf_size > 16'd0) ? cfg.buf_size - 16'd1 : 16'd0;
	assign terminated = !end_item;
	assign line_bytes = end_item ? bytes_q : bytes_inc;
	assign do_close_line = end_item ? (bytes_q != 16'd0) : cls.is_newline;

	// closing a line folds in its last field and records the first error
	always_comb begin
		cl_lerr = lerr_q;
		if (content_q) begin
			cl_lerr = cf_err;
			if (cf_field < wanted && cf_err == ST_OK) cl_lerr = ST_FEW;
		end
		cl_lines = (lines_q < LINES_MAX) ? lines_q + 24'd1 : lines_q;
		cl_err = (!terminated || line_bytes > limit) ? ST_LONG : cl_lerr;
		cl_ferr = ferr_q;
		cl_ferr_line = ferr_line_q;
		cl_ferr_field = ferr_field_q;
		if (ferr_q == ST_OK && cl_err != ST_OK) begin
			cl_ferr = cl_err;
			cl_ferr_line = cl_lines;
			cl_ferr_field = (cl_err == ST_WIDE) ? (content_q ? cf_err_field : lerr_field_q)
				: 4'd0;
		end
	end

	// report at end of input
	always_comb begin
		logic [2:0]  e;
		logic [23:0] ln;
		logic [3:0]  fn;
		logic [23:0] tot;
		e = do_close_line ? cl_ferr : ferr_q;
		ln = do_close_line ? cl_ferr_line : ferr_line_q;
		fn = do_close_line ? cl_ferr_field : ferr_field_q;
		tot = do_close_line ? cl_lines : lines_q;
		if (e != ST_OK) begin
			result.status = e;
			result.line_number = ln;
			result.field_number = fn;
		end else begin
			result.status = ST_OK;
			result.line_number = tot;
			result.field_number = 4'd0;
		end
	end

	assign trim_sum = {1'b0, trim_q} + {1'b0, spaces_q} + 9'd1;

	// per-item state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lines_q <= '0;
			bytes_q <= '0;
			field_q <= '0;
			comment_q <= 1'b0;
			content_q <= 1'b0;
			started_q <= 1'b0;
			trim_q <= '0;
			spaces_q <= '0;
			lerr_q <= ST_OK;
			lerr_field_q <= '0;
			ferr_q <= ST_OK;
			ferr_line_q <= '0;
			ferr_field_q <= '0;
		end else if (step) begin
			if (end_item || cls.is_newline) begin
				// line ends: clear line state, then restart or keep totals
				bytes_q <= '0;
				field_q <= '0;
				comment_q <= 1'b0;
				content_q <= 1'b0;
				started_q <= 1'b0;
				trim_q <= '0;
				spaces_q <= '0;
				lerr_q <= ST_OK;
				lerr_field_q <= '0;
				if (end_item) begin
					lines_q <= '0;
					ferr_q <= ST_OK;
					ferr_line_q <= '0;
					ferr_field_q <= '0;
				end else begin
					lines_q <= cl_lines;
					ferr_q <= cl_ferr;
					ferr_line_q <= cl_ferr_line;
					ferr_field_q <= cl_ferr_field;
				end
			end else begin
				bytes_q <= bytes_inc;
				if (comment_q) begin
					// dropped
				end else if (cls.is_comment) begin
					comment_q <= 1'b1;
				end else begin
					content_q <= 1'b1;
					if (cls.is_delim) begin
						lerr_q <= cf_err;
						lerr_field_q <= cf_err_field;
						field_q <= cf_field;
						started_q <= 1'b0;
						trim_q <= '0;
						spaces_q <= '0;
					end else if (cls.is_space) begin
						if (started_q && spaces_q < 8'hFF) spaces_q <= spaces_q + 8'd1;
					end else begin
						if (started_q) begin
							trim_q <= trim_sum[8] ? 8'hFF : trim_sum[7:0];
						end else begin
							trim_q <= 8'd1;
							started_q <= 1'b1;
						end
						spaces_q <= '0;
					end
				end
			end
		end
	end

endmodule

// File: verif/tb_delimited_line_field_checker.sv
`timescale 1ns / 1ps

module tb_delimited_line_field_checker;
	import dlfc_pkg::*;

	// slowest legal run stays well under CYCLE_LIMIT (every item after the longest idle gap,
	// every report held for the longest stall, one long hold-off)
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int HOLD_CYCLES = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam int FIELD_SLOTS = MaxFieldsDefault;

	typedef struct packed {
		logic [7:0] text;
		logic       eoi;
	} text_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  text_byte = '0;
	logic        end_of_input = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [23:0] line_number;
	logic [3:0]  field_number;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_DELIMITER;
	logic [63:0] cfg_data = '0;

	delimited_line_field_checker dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.text_byte    (text_byte),
		.end_of_input (end_of_input),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.line_number  (line_number),
		.field_number (field_number),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// checker configuration as the block should hold it
	logic [7:0]  chk_delim;
	logic [3:0]  chk_count;
	logic [15:0] chk_bufsize;
	logic [63:0] chk_widths;

	// line scanner state
	logic [23:0] lines_total;
	logic [15:0] line_bytes;
	logic [3:0]  field_idx;
	logic        comment_on;
	logic        has_content;
	logic        field_open;
	logic [7:0]  field_len;
	logic [7:0]  gap_spaces;
	logic [2:0]  line_fault;
	logic [3:0]  line_fault_field;
	logic [2:0]  file_fault;
	logic [23:0] file_fault_line;
	logic [3:0]  file_fault_field;

	text_item_t pending_text[$];
	result_t    expected_reports[$];

	int stim_items = 0;
	int files_sent = 0;
	int configs_loaded = 0;
	int reports_checked = 0;
	int mismatches = 0;
	int cycles = 0;

	function automatic int fields_wanted();
		return (int'(chk_count) > FIELD_SLOTS) ? FIELD_SLOTS : int'(chk_count);
	endfunction

	function automatic bit is_blank(logic [7:0] b);
		return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
	endfunction

	function automatic void clear_field_state();
		field_open = 1'b0;
		field_len = '0;
		gap_spaces = '0;
	endfunction

	function automatic void clear_line_state();
		line_bytes = '0;
		field_idx = '0;
		comment_on = 1'b0;
		has_content = 1'b0;
		line_fault = ST_OK;
		line_fault_field = '0;
		clear_field_state();
	endfunction

	// width check of the field just ended, or too many fields
	function automatic void close_field_state();
		int idx;
		logic [7:0] lim;
		idx = int'(field_idx);
		if (idx < fields_wanted()) begin
			lim = chk_widths[8*idx +: 8];
			if (lim != 8'hFF && field_len >= lim && line_fault == ST_OK) begin
				line_fault = ST_WIDE;
				line_fault_field = 4'(idx + 1);
			end
		end else if (line_fault == ST_OK) begin
			line_fault = ST_MANY;
		end
		if (field_idx != 4'hF)
			field_idx = field_idx + 4'd1;
		clear_field_state();
	endfunction

	// end of line: field count, length and first-error bookkeeping
	function automatic void close_line_state(bit terminated);
		int limit;
		logic [2:0] err;
		limit = (chk_bufsize != 0) ? int'(chk_bufsize) - 1 : 0;
		if (has_content) begin
			close_field_state();
			if (int'(field_idx) < fields_wanted() && line_fault == ST_OK)
				line_fault = ST_FEW;
		end
		if (lines_total != LINES_MAX)
			lines_total = lines_total + 24'd1;
		err = (!terminated || int'(line_bytes) > limit) ? ST_LONG : line_fault;
		if (file_fault == ST_OK && err != ST_OK) begin
			file_fault = err;
			file_fault_line = lines_total;
			file_fault_field = (err == ST_WIDE) ? line_fault_field : 4'd0;
		end
		clear_line_state();
	endfunction

	function automatic void restart_file();
		lines_total = '0;
		file_fault = ST_OK;
		file_fault_line = '0;
		file_fault_field = '0;
		clear_line_state();
	endfunction

	function automatic void reset_checker();
		chk_delim = DELIMITER_RESET;
		chk_count = FIELD_COUNT_RESET;
		chk_bufsize = BUFFER_SIZE_RESET;
		chk_widths = FIELD_WIDTHS_RESET;
		restart_file();
	endfunction

	// advance the scanner by one accepted item, queue a report on end of file
	function automatic void scan_byte(logic [7:0] b, logic eoi);
		result_t r;
		int n;
		if (eoi) begin
			if (line_bytes != 0)
				close_line_state(1'b0);
			if (file_fault != ST_OK) begin
				r.status = file_fault;
				r.line_number = file_fault_line;
				r.field_number = file_fault_field;
			end else begin
				r.status = ST_OK;
				r.line_number = lines_total;
				r.field_number = '0;
			end
			expected_reports.push_back(r);
			restart_file();
		end else begin
			if (line_bytes != 16'hFFFF)
				line_bytes = line_bytes + 16'd1;
			if (b == CH_NEWLINE) begin
				close_line_state(1'b1);
			end else if (comment_on) begin
				// dropped until newline
			end else if (b == CH_COMMENT) begin
				comment_on = 1'b1;
			end else begin
				has_content = 1'b1;
				if (b == chk_delim) begin
					close_field_state();
				end else if (is_blank(b)) begin
					if (field_open && gap_spaces != 8'hFF)
						gap_spaces = gap_spaces + 8'd1;
				end else begin
					if (field_open) begin
						n = int'(field_len) + int'(gap_spaces) + 1;
						field_len = (n > 255) ? 8'hFF : 8'(n);
					end else begin
						field_len = 8'd1;
						field_open = 1'b1;
					end
					gap_spaces = '0;
				end
			end
		end
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// sender
	int send_wait = 0;
	int send_calm = 0;
	text_item_t next_item;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			text_byte <= '0;
			end_of_input <= 1'b0;
			send_wait <= 0;
			send_calm <= 0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid)
				scan_byte(text_byte, end_of_input);
			if (send_wait != 0) begin
				in_valid <= 1'b0;
				send_wait <= send_wait - 1;
			end else if (pending_text.size() != 0) begin
				next_item = pending_text.pop_front();
				text_byte <= next_item.text;
				end_of_input <= next_item.eoi;
				in_valid <= 1'b1;
				if (send_calm != 0) begin
					send_calm <= send_calm - 1;
					send_wait <= 0;
				end else if ($urandom_range(0, 199) == 0) begin
					send_calm <= $urandom_range(50, 300);
					send_wait <= 0;
				end else begin
					send_wait <= idle_len();
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall, with one long hold-off on request
	logic hold_req = 1'b0;
	logic hold_used;
	int hold_left;
	int stall_left;
	int stall_calm;
	int stall_pick;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_used <= 1'b0;
			hold_left <= 0;
			stall_left <= 0;
			stall_calm <= 0;
		end else if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_used) begin
			out_stall <= 1'b1;
			hold_used <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end else if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (stall_calm != 0) begin
			out_stall <= 1'b0;
			stall_calm <= stall_calm - 1;
		end else if ($urandom_range(0, 149) == 0) begin
			out_stall <= 1'b0;
			stall_calm <= $urandom_range(50, 300);
		end else begin
			stall_pick = idle_len();
			out_stall <= (stall_pick != 0);
			stall_left <= (stall_pick != 0) ? stall_pick - 1 : 0;
		end
	end

	// compare each accepted report with the oldest expected one
	result_t report_want;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_reports.size() == 0) begin
				$display("%0t: unexpected report status=%0d line=%0d field=%0d",
					$time, status, line_number, field_number);
				mismatches++;
			end else begin
				report_want = expected_reports.pop_front();
				reports_checked++;
				if (status !== report_want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, report_want.status, status);
					mismatches++;
				end
				if (line_number !== report_want.line_number) begin
					$display("%0t: line_number expected %0d actual %0d",
						$time, report_want.line_number, line_number);
					mismatches++;
				end
				if (field_number !== report_want.field_number) begin
					$display("%0t: field_number expected %0d actual %0d",
						$time, report_want.field_number, field_number);
					mismatches++;
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d reports outstanding",
				cycles, expected_reports.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// stimulus helpers
	task automatic send_byte(input logic [7:0] b);
		text_item_t it;
		it.text = b;
		it.eoi = 1'b0;
		pending_text.push_back(it);
		stim_items++;
	endtask

	task automatic send_str(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_run(input logic [7:0] b, input int n);
		repeat (n) send_byte(b);
	endtask

	task automatic end_file();
		text_item_t it;
		it.text = 8'($urandom);
		it.eoi = 1'b1;
		pending_text.push_back(it);
		stim_items++;
		files_sent++;
	endtask

	function automatic logic [7:0] pick_plain();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == CH_NEWLINE || b == CH_COMMENT || b == chk_delim || is_blank(b));
		return b;
	endfunction

	function automatic logic [7:0] pick_blank();
		logic [7:0] b;
		do begin
			case ($urandom_range(0, 4))
				0: b = CH_SPACE;
				1: b = CH_TAB;
				2: b = 8'h0B;
				3: b = 8'h0C;
				default: b = CH_CR;
			endcase
		end while (b == chk_delim);
		return b;
	endfunction

	function automatic logic [7:0] pick_not_newline();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == CH_NEWLINE);
		return b;
	endfunction

	// one field of a given trimmed length, padded with blanks
	task automatic send_field(input int len);
		repeat ($urandom_range(0, 2)) send_byte(pick_blank());
		for (int i = 0; i < len; i++) begin
			if (i > 0 && $urandom_range(0, 4) == 0)
				send_byte(pick_blank());
			send_byte(pick_plain());
		end
		repeat ($urandom_range(0, 2)) send_byte(pick_blank());
	endtask

	// line of nf fields within nonzero limits, one field made too wide if asked and its limit is at most 16
	task automatic send_line(input int nf, input bit widen);
		int wide_at;
		int lim;
		int len;
		wide_at = (nf > 0) ? $urandom_range(0, nf - 1) : -1;
		for (int f = 0; f < nf; f++) begin
			if (f > 0)
				send_byte(chk_delim);
			lim = (f < FIELD_SLOTS) ? int'(chk_widths[8*f +: 8]) : 255;
			if (widen && f == wide_at && lim <= 16)
				len = lim;
			else if (lim == 255)
				len = $urandom_range(0, 6);
			else if (lim == 0)
				len = 0;
			else
				len = $urandom_range(0, (lim - 1 < 8) ? lim - 1 : 8);
			send_field(len);
		end
		if ($urandom_range(0, 4) == 0) begin
			send_byte(CH_COMMENT);
			repeat ($urandom_range(0, 5)) send_byte(pick_not_newline());
		end
		send_byte(CH_NEWLINE);
	endtask

	// mostly well-formed lines, some broken ones, blanks and noise
	task automatic send_random_file();
		int kind;
		repeat ($urandom_range(0, 4)) begin
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				send_line(fields_wanted(), 1'b0);
			end else if (kind < 78) begin
				send_line(fields_wanted(), 1'b1);
			end else if (kind < 86) begin
				send_line(fields_wanted() + ($urandom_range(0, 1) ? 1 : -1), 1'b0);
			end else if (kind < 93) begin
				if ($urandom_range(0, 1))
					send_str("# note");
				send_byte(CH_NEWLINE);
			end else begin
				repeat ($urandom_range(1, 12)) send_byte(pick_not_newline());
				send_byte(CH_NEWLINE);
			end
		end
		// unterminated last line now and then
		if ($urandom_range(0, 11) == 0)
			repeat ($urandom_range(1, 4)) send_byte(pick_not_newline());
		end_file();
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_text.size() != 0 || in_valid || expected_reports.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input logic [1:0] idx, input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// write all four registers, junk above the narrow ones
	task automatic load_config(input logic [7:0] d, input logic [3:0] n,
			input logic [15:0] bs, input logic [63:0] w);
		put_reg(REG_DELIMITER, {$urandom, 24'($urandom), d});
		put_reg(REG_FIELD_COUNT, {$urandom, 28'($urandom), n});
		put_reg(REG_BUFFER_SIZE, {$urandom, 16'($urandom), bs});
		put_reg(REG_FIELD_WIDTHS, w);
		cfg_we <= 1'b0;
		chk_delim = d;
		chk_count = n;
		chk_bufsize = bs;
		chk_widths = w;
		configs_loaded++;
	endtask

	task automatic random_setup();
		logic [7:0] d;
		logic [3:0] n;
		logic [15:0] bs;
		logic [63:0] w;
		int r;
		case ($urandom_range(0, 5))
			0: d = ";";
			1: d = ",";
			2: d = "|";
			3: d = CH_TAB;
			4: d = CH_SPACE;
			default: d = 8'($urandom);
		endcase
		if ($urandom_range(0, 9) < 7)
			n = 4'($urandom_range(1, 8));
		else if ($urandom_range(0, 2) == 0)
			n = 4'd0;
		else
			n = 4'($urandom_range(9, 15));
		if ($urandom_range(0, 9) < 8) begin
			bs = 16'($urandom_range(20, 300));
		end else begin
			case ($urandom_range(0, 4))
				0: bs = 16'd0;
				1: bs = 16'd1;
				2: bs = 16'd2;
				3: bs = 16'd3;
				default: bs = 16'hFFFF;
			endcase
		end
		for (int i = 0; i < 8; i++) begin
			r = $urandom_range(0, 19);
			w[8*i +: 8] = (r < 10) ? 8'hFF : (r < 18) ? 8'($urandom_range(2, 12)) :
				(r == 18) ? 8'h01 : 8'h00;
		end
		load_config(d, n, bs, w);
	endtask

	initial begin
		bit pressure_done;
		pressure_done = 1'b0;
		reset_checker();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset configuration: basic files, field count errors, partial line
		end_file();
		send_str("a;b;c\n");
		end_file();
		// one character before a comment is content
		send_str("x#note\n");
		end_file();
		// all-blank fields, comment-only and empty lines
		send_str(" ;\t; \n# c\n\n");
		end_file();
		// first error wins
		send_str("a;b\na;b;c;d\n");
		end_file();
		send_str("a;b;c\na;b;c;d\n");
		end_file();
		send_str("a;b;c\nab");
		end_file();
		// zero byte is plain text
		send_byte(8'h00);
		send_str(";b;c\n");
		end_file();
		wait_idle();

		// zero delimiter, count above the field slots, largest buffer
		load_config(8'h00, 4'hF, 16'hFFFF, {{7{8'hFF}}, 8'hFE});
		// trimmed length saturates
		send_run("x", 300);
		send_run(8'h00, 7);
		send_byte(CH_NEWLINE);
		end_file();
		// inner blank run saturates
		send_byte("a");
		send_run(CH_SPACE, 300);
		send_byte("b");
		send_run(8'h00, 7);
		send_byte(CH_NEWLINE);
		end_file();
		// field index saturates
		send_run(8'h00, 20);
		send_byte(CH_NEWLINE);
		end_file();
		send_run(8'h00, 7);
		send_byte(CH_NEWLINE);
		end_file();
		wait_idle();

		// field count zero, delimiter 0xff, every width zero
		load_config(8'hFF, 4'd0, 16'd300, 64'h0);
		send_byte("a");
		send_byte(8'hFF);
		send_str("b\n\n");
		end_file();
		wait_idle();

		// comment character as delimiter, buffer size zero
		load_config(CH_COMMENT, 4'd2, 16'd0, '1);
		send_str("a#b\n");
		end_file();
		wait_idle();

		// newline as delimiter, buffer size one
		load_config(CH_NEWLINE, 4'd1, 16'd1, '1);
		send_str("\n");
		end_file();
		wait_idle();

		// blank as delimiter, buffer size two
		load_config(CH_SPACE, 4'd3, 16'd2, '1);
		send_str("\n");
		end_file();
		send_str("\na b c\n");
		end_file();
		wait_idle();

		// blank delimiter with width limits on the first two fields
		load_config(CH_SPACE, 4'd3, 16'd100, {{6{8'hFF}}, 8'h02, 8'h03});
		send_str("ab\tc d e\n");
		end_file();
		send_str("ab c d\na bc d\n");
		end_file();
		send_str("a b  c\n");
		end_file();

		// random configurations and files
		while (stim_items < 1550) begin
			wait_idle();
			random_setup();
			if (!pressure_done) begin
				// receiver holds off while files keep coming
				hold_req <= 1'b1;
				pressure_done = 1'b1;
				repeat (6) send_random_file();
			end
			repeat (4) send_random_file();
		end
		wait_idle();

		$display("checked %0d end-of-file reports from %0d items under %0d register settings",
			reports_checked, stim_items, configs_loaded + 1);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: sim.f
rtl/dlfc_pkg.sv
rtl/dlfc_byte_class.sv
rtl/dlfc_line_state.sv
rtl/delimited_line_field_checker.sv
verif/tb_delimited_line_field_checker.sv
